FILE: design/stack_queue_with_value_delete_assert.svh
// Assertion macros for the stack/queue block.
`ifndef STACK_QUEUE_WITH_VALUE_DELETE_ASSERT_SVH
`define STACK_QUEUE_WITH_VALUE_DELETE_ASSERT_SVH

`ifndef SYNTHESIS

// ante implies cons in the same cycle
`define SQVD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// ante implies cons in the next cycle
`define SQVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SQVD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SQVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/sqvd_pkg.sv
package sqvd_pkg;

  localparam int DATA_W   = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REM_HEAD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REM_VAL  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } ctl_state_t;

  typedef struct packed {
    logic accept;  // latch request, register compare vector
    logic apply;   // commit list update and load result register
  } ctl_cmd_t;

endpackage

FILE: design/stack_queue_with_value_delete.sv
// Bounded ordered list of up to DEPTH 32-bit values, run as a stack
// (cfg bit 0: insert at head) or a queue (cfg bit 1: insert at tail), with
// remove-head and remove-first-matching-value requests; every request item
// yields one result item carrying status, the removed value and the count
// after the request. At the accept edge every list cell compares its entry
// with the request value in parallel; then, in the update state, the list
// shifts and the result register loads. The update waits while the result
// register still holds an item not yet taken; requests stall meanwhile.
// Entry storage needs no clearing after reset; the count alone marks valid
// cells. Write the mode bit only while no request is in flight.
`include "stack_queue_with_value_delete_assert.svh"

module stack_queue_with_value_delete #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sqvd_pkg::REQ_W-1:0]    in_req_type,
  input  logic [sqvd_pkg::DATA_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sqvd_pkg::STATUS_W-1:0] out_status,
  output logic [sqvd_pkg::DATA_W-1:0]   out_removed_value,
  output logic [sqvd_pkg::COUNT_W-1:0]  out_entry_count
);

  sqvd_pkg::ctl_cmd_t cmd;

  sqvd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sqvd_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count)
  );

  `SQVD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `SQVD_ASSERT_SAME(a_cmd_exclusive, clk, rst_n, 1'b1, !(cmd.accept && cmd.apply))
  `SQVD_ASSERT_NEXT(a_apply_shows_result, clk, rst_n, cmd.apply, out_valid)
  `SQVD_ASSERT_SAME(a_accept_only_idle, clk, rst_n, cmd.accept, !in_stall && in_valid)

endmodule

FILE: design/sqvd_ctrl.sv
module sqvd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output sqvd_pkg::ctl_cmd_t cmd
);

  sqvd_pkg::ctl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqvd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sqvd_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sqvd_pkg::S_UPDATE;
      end
      sqvd_pkg::S_UPDATE: begin
        // hold until the result register can take the new item
        if (out_free) state_nxt = sqvd_pkg::S_IDLE;
      end
      default: state_nxt = sqvd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.accept    = 1'b0;
    cmd.apply     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      sqvd_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      sqvd_pkg::S_UPDATE: begin
        cmd.apply = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/sqvd_datapath.sv
module sqvd_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sqvd_pkg::ctl_cmd_t                  cmd,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic [sqvd_pkg::REQ_W-1:0]          in_req_type,
  input  logic [sqvd_pkg::DATA_W-1:0]         in_value,
  output logic [sqvd_pkg::STATUS_W-1:0]       out_status,
  output logic [sqvd_pkg::DATA_W-1:0]         out_removed_value,
  output logic [sqvd_pkg::COUNT_W-1:0]        out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [sqvd_pkg::DATA_W-1:0]   ent_r   [DEPTH];
  logic [sqvd_pkg::DATA_W-1:0]   ent_nxt [DEPTH];
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          mode_r;
  logic [sqvd_pkg::REQ_W-1:0]    req_r;
  logic [sqvd_pkg::DATA_W-1:0]   val_r;
  logic [DEPTH-1:0]              match_r;

  logic [sqvd_pkg::STATUS_W-1:0] status;
  logic [sqvd_pkg::DATA_W-1:0]   removed;
  logic [DEPTH-1:0]              first_hit, hit_pfx, sel, shift;
  logic                          found, full, empty;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);

  // first match from the head and the cells at or behind it
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      first_hit[i] = match_r[i] && !acc;
      acc          = acc || match_r[i];
      hit_pfx[i]   = acc;
    end
    found = acc;
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) ent_nxt[i] = ent_r[i];
    cnt_nxt = cnt_r;
    status  = sqvd_pkg::ST_OK;
    removed = '0;
    sel     = '0;
    shift   = '0;

    unique case (req_r)
      sqvd_pkg::REQ_INSERT: begin
        if (full) begin
          status = sqvd_pkg::ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          if (!mode_r) begin
            ent_nxt[0] = val_r;
            for (int i = 1; i < DEPTH; i++) ent_nxt[i] = ent_r[i-1];
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (CW'(i) == cnt_r) ent_nxt[i] = val_r;
            end
          end
        end
      end
      sqvd_pkg::REQ_REM_HEAD: begin
        if (empty) begin
          status = sqvd_pkg::ST_EMPTY;
        end else begin
          sel[0] = 1'b1;
          shift  = '1;
        end
      end
      sqvd_pkg::REQ_REM_VAL: begin
        if (empty) begin
          status = sqvd_pkg::ST_EMPTY;
        end else if (!found) begin
          status = sqvd_pkg::ST_NOTFOUND;
        end else begin
          sel   = first_hit;
          shift = hit_pfx;
        end
      end
      default: ;
    endcase

    // removal: pull the tail side up by one from the taken cell onward
    if (|shift) begin
      cnt_nxt = cnt_r - CW'(1);
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (shift[i]) ent_nxt[i] = ent_r[i+1];
      end
      for (int i = 0; i < DEPTH; i++) begin
        removed = removed | (ent_r[i] & {sqvd_pkg::DATA_W{sel[i]}});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mode_r <= 1'b0;
    end else begin
      if (cmd.apply) cnt_r <= cnt_nxt;
      if (cfg_wr_en) mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_req_type;
      val_r <= in_value;
      for (int i = 0; i < DEPTH; i++) begin
        match_r[i] <= (ent_r[i] == in_value) && (CW'(i) < cnt_r);
      end
    end
    if (cmd.apply) begin
      for (int i = 0; i < DEPTH; i++) ent_r[i] <= ent_nxt[i];
      out_status        <= status;
      out_removed_value <= removed;
      out_entry_count   <= sqvd_pkg::COUNT_W'(cnt_nxt);
    end
  end

endmodule
